// File: hw/rtl/grid_nearest_two_class_distance_defines.svh
// ----------------------------------------------------------------------------
// Grid nearest two-class distance: assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef GRID_NEAREST_TWO_CLASS_DISTANCE_DEFINES_SVH
`define GRID_NEAREST_TWO_CLASS_DISTANCE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GNTCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define GNTCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also runs while reset is high.
`define GNTCD_ASSERT_RESET(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/gntcd_pkg.sv
// ----------------------------------------------------------------------------
// Grid nearest two-class distance: package
// Class codes, register indexes, controller states and control bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gntcd_pkg;

  localparam int CLASS_W     = 2;
  localparam int COUNT_W     = 11;
  localparam int DIST_W      = 11;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CLASS_W-1:0] CLASS_EMPTY  = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_FIRST  = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_SECOND = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_UNUSED = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 1'd1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL,
    ST_SWEEP,
    ST_TAIL,
    ST_ROW_END
  } state_t;

  // Raster pass: a cell is taken into the line-buffer read stage.
  typedef struct packed {
    logic take;
    logic first_row;
  } cell_ctl_t;

  // Right-to-left sweep: one column read is issued.
  typedef struct packed {
    logic issue;
    logic first_row;
    logic first_col;
  } sweep_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/grid_nearest_two_class_distance.sv
// ----------------------------------------------------------------------------
// Grid nearest two-class distance: top level
// Raster-order cell input, one distance result per grid.
// ----------------------------------------------------------------------------
// Cells arrive row by row, left to right; each is empty, first class or
// second class (code three counts as empty). Within a row one cell is taken
// every cycle. After the last cell of a row the block stops taking cells
// while a right-to-left sweep reads one column a cycle from the two
// line-buffer memories and its pipeline drains. After the last row one
// result item carries the smallest Manhattan distance plus one (0 with
// pair_found low when no pair exists), and the block starts the next grid.
// The line buffers need no clearing pass: the first row of each grid
// ignores what they hold. A write to either count register restarts the
// grid; counts of zero act as one and counts above the limits act as
// the limits.
`timescale 1ns / 1ps
`default_nettype none

module grid_nearest_two_class_distance #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [gntcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gntcd_pkg::COUNT_W-1:0]     cfg_data,
  input  logic                              cell_valid,
  output logic                              cell_ready,
  input  logic [gntcd_pkg::CLASS_W-1:0]     cell_class,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [gntcd_pkg::DIST_W-1:0]      distance_plus_one,
  output logic                              pair_found
);

  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int KEY_W   = $clog2(MAX_ROWS + MAX_COLUMNS + 1);
  localparam int LIMIT_W = 13;
  localparam int SUM_W   = KEY_W + 1;
  localparam int EXT_W   = (SUM_W > gntcd_pkg::DIST_W) ? SUM_W : gntcd_pkg::DIST_W;

  function automatic logic [LIMIT_W-1:0] last_of(input logic [gntcd_pkg::COUNT_W-1:0] count,
                                                 input logic [LIMIT_W-1:0] limit);
    logic [LIMIT_W-1:0] wide;
    wide = LIMIT_W'(count);
    if (wide == '0) begin
      return '0;
    end
    if (wide > limit) begin
      return limit - LIMIT_W'(1);
    end
    return wide - LIMIT_W'(1);
  endfunction

  gntcd_pkg::state_t state, state_next;

  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;
  logic [COL_W-1:0] column_index;
  logic [ROW_W-1:0] row_index;
  logic             cell_last;
  logic [COL_W-1:0] sweep_col;
  logic [KEY_W-1:0] best;
  logic             found;

  logic cell_take, sweep_issue, row_advance, grid_done;

  gntcd_pkg::cell_ctl_t          cell_ctl;
  gntcd_pkg::sweep_ctl_t         sweep_ctl;
  logic [gntcd_pkg::CLASS_W-1:0] sweep_class;
  logic                          p1_valid, p2_valid, cand_any;
  logic [KEY_W-1:0]              p1_dist, p2_dist, cand;
  logic [EXT_W-1:0]              dist_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gntcd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cell_ready  = 1'b0;
    sweep_issue = 1'b0;
    row_advance = 1'b0;
    grid_done   = 1'b0;
    unique case (state)
      gntcd_pkg::ST_IDLE: begin
        cell_ready = 1'b1;
        if (cell_valid) begin
          state_next = gntcd_pkg::ST_CELL;
        end
      end
      gntcd_pkg::ST_CELL: begin
        // the last cell of a row hands over to the sweep
        cell_ready = !cell_last;
        if (cell_last) begin
          state_next = gntcd_pkg::ST_SWEEP;
        end else if (!cell_valid) begin
          state_next = gntcd_pkg::ST_IDLE;
        end
      end
      gntcd_pkg::ST_SWEEP: begin
        sweep_issue = 1'b1;
        if (sweep_col == '0) begin
          state_next = gntcd_pkg::ST_TAIL;
        end
      end
      gntcd_pkg::ST_TAIL: begin
        state_next = gntcd_pkg::ST_ROW_END;
      end
      gntcd_pkg::ST_ROW_END: begin
        if (row_index != row_last) begin
          row_advance = 1'b1;
          state_next  = gntcd_pkg::ST_IDLE;
        end else if (!result_valid || result_ready) begin
          grid_done  = 1'b1;
          state_next = gntcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gntcd_pkg::ST_IDLE;
      end
    endcase
  end

  assign cell_take = cell_valid && cell_ready;

  always_comb begin
    cell_ctl.take       = cell_take;
    cell_ctl.first_row  = (row_index == '0);
    sweep_ctl.issue     = sweep_issue;
    sweep_ctl.first_row = (row_index == '0);
    sweep_ctl.first_col = (sweep_col == col_last);
    cand_any            = p1_valid || p2_valid;
    cand                = p1_valid ? p1_dist : p2_dist;
    dist_ext            = EXT_W'({1'b0, best} + SUM_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_last     <= COL_W'(last_of(gntcd_pkg::COUNT_RESET, LIMIT_W'(MAX_COLUMNS)));
      row_last     <= ROW_W'(last_of(gntcd_pkg::COUNT_RESET, LIMIT_W'(MAX_ROWS)));
      column_index <= '0;
      row_index    <= '0;
      cell_last    <= 1'b0;
      found        <= 1'b0;
      result_valid <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gntcd_pkg::REG_ROW_COUNT: begin
          row_last <= ROW_W'(last_of(cfg_data, LIMIT_W'(MAX_ROWS)));
        end
        gntcd_pkg::REG_COLUMN_COUNT: begin
          col_last <= COL_W'(last_of(cfg_data, LIMIT_W'(MAX_COLUMNS)));
        end
        default: begin
        end
      endcase
      column_index <= '0;
      row_index    <= '0;
      found        <= 1'b0;
    end else begin
      if (cell_take) begin
        cell_last    <= (column_index == col_last);
        column_index <= (column_index == col_last) ? '0 : column_index + COL_W'(1);
      end
      if (cand_any) begin
        found <= 1'b1;
      end
      if (row_advance) begin
        row_index <= row_index + ROW_W'(1);
      end
      if (grid_done) begin
        row_index    <= '0;
        found        <= 1'b0;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cand_any && (!found || cand < best)) begin
      best <= cand;
    end
    // hold the start column until the sweep runs, then count down
    if (state == gntcd_pkg::ST_SWEEP) begin
      sweep_col <= sweep_col - COL_W'(1);
    end else begin
      sweep_col <= col_last;
    end
    if (grid_done) begin
      distance_plus_one <= found ? dist_ext[gntcd_pkg::DIST_W-1:0] : '0;
      pair_found        <= found;
    end
  end

  gntcd_upleft #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_upleft (
    .clk         (clk),
    .rst         (rst),
    .cell_ctl    (cell_ctl),
    .cell_col    (column_index),
    .cell_row    (row_index),
    .cell_class  (cell_class),
    .sweep_read  (sweep_issue),
    .sweep_col   (sweep_col),
    .sweep_class (sweep_class),
    .cand_valid  (p1_valid),
    .cand_dist   (p1_dist)
  );

  gntcd_upright #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_upright (
    .clk         (clk),
    .rst         (rst),
    .sweep_ctl   (sweep_ctl),
    .sweep_col   (sweep_col),
    .sweep_row   (row_index),
    .sweep_class (sweep_class),
    .cand_valid  (p2_valid),
    .cand_dist   (p2_dist)
  );

endmodule

`default_nettype wire

// File: hw/rtl/gntcd_upleft.sv
// ----------------------------------------------------------------------------
// Grid nearest two-class distance: up-left line buffer
// Raster pass. Holds the cell class and the greatest row+col+2 of each class
// per column; read, update and write back one cell per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gntcd_upleft #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024,
  localparam int COL_W = $clog2(MAX_COLUMNS),
  localparam int ROW_W = $clog2(MAX_ROWS),
  localparam int KEY_W = $clog2(MAX_ROWS + MAX_COLUMNS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gntcd_pkg::cell_ctl_t          cell_ctl,
  input  logic [COL_W-1:0]              cell_col,
  input  logic [ROW_W-1:0]              cell_row,
  input  logic [gntcd_pkg::CLASS_W-1:0] cell_class,
  input  logic                          sweep_read,
  input  logic [COL_W-1:0]              sweep_col,
  output logic [gntcd_pkg::CLASS_W-1:0] sweep_class,
  output logic                          cand_valid,
  output logic [KEY_W-1:0]              cand_dist
);

  localparam int WORD_W = gntcd_pkg::CLASS_W + 2 * KEY_W;

  logic [WORD_W-1:0] mem [MAX_COLUMNS];
  logic [WORD_W-1:0] rd_word;

  logic                          stg_valid;
  logic                          stg_first_row;
  logic [COL_W-1:0]              stg_col;
  logic [gntcd_pkg::CLASS_W-1:0] stg_class;
  logic [KEY_W-1:0]              stg_key;
  logic [KEY_W-1:0]              left_first;
  logic [KEY_W-1:0]              left_second;

  logic [gntcd_pkg::CLASS_W-1:0] in_class;
  logic [KEY_W-1:0] up_first, up_second, lf_first, lf_second;
  logic [KEY_W-1:0] max_first, max_second, new_first, new_second;

  always_comb begin
    in_class = (cell_class == gntcd_pkg::CLASS_UNUSED) ? gntcd_pkg::CLASS_EMPTY : cell_class;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else begin
      stg_valid <= cell_ctl.take;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_ctl.take) begin
      rd_word       <= mem[cell_col];
      stg_col       <= cell_col;
      stg_class     <= in_class;
      stg_first_row <= cell_ctl.first_row;
      stg_key       <= KEY_W'(cell_row) + KEY_W'(cell_col) + KEY_W'(2);
    end
    if (sweep_read) begin
      sweep_class <= mem[sweep_col][WORD_W-1 -: gntcd_pkg::CLASS_W];
    end
    if (stg_valid) begin
      mem[stg_col] <= {stg_class, new_first, new_second};
      left_first   <= new_first;
      left_second  <= new_second;
    end
  end

  always_comb begin
    // the first row sees nothing above it, whatever the buffer holds
    up_first   = stg_first_row ? '0 : rd_word[2*KEY_W-1 -: KEY_W];
    up_second  = stg_first_row ? '0 : rd_word[KEY_W-1:0];
    lf_first   = (stg_col == '0) ? '0 : left_first;
    lf_second  = (stg_col == '0) ? '0 : left_second;
    max_first  = (up_first > lf_first) ? up_first : lf_first;
    max_second = (up_second > lf_second) ? up_second : lf_second;
    new_first  = max_first;
    new_second = max_second;
    cand_valid = 1'b0;
    cand_dist  = '0;
    case (stg_class)
      gntcd_pkg::CLASS_FIRST: begin
        cand_valid = stg_valid && (max_second != '0);
        cand_dist  = stg_key - max_second;
        new_first  = stg_key;
      end
      gntcd_pkg::CLASS_SECOND: begin
        cand_valid = stg_valid && (max_first != '0);
        cand_dist  = stg_key - max_first;
        new_second = stg_key;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/gntcd_upright.sv
// ----------------------------------------------------------------------------
// Grid nearest two-class distance: up-right line buffer
// Right-to-left sweep over a finished row. Holds the greatest row-col of
// each class per column; read, update and write back one column per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gntcd_upright #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024,
  localparam int COL_W  = $clog2(MAX_COLUMNS),
  localparam int ROW_W  = $clog2(MAX_ROWS),
  localparam int KEY_W  = $clog2(MAX_ROWS + MAX_COLUMNS + 1),
  localparam int SIGN_W = $clog2((MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS) + 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gntcd_pkg::sweep_ctl_t         sweep_ctl,
  input  logic [COL_W-1:0]              sweep_col,
  input  logic [ROW_W-1:0]              sweep_row,
  input  logic [gntcd_pkg::CLASS_W-1:0] sweep_class,
  output logic                          cand_valid,
  output logic [KEY_W-1:0]              cand_dist
);

  localparam logic signed [SIGN_W-1:0] NONE_MARK = {1'b1, {(SIGN_W-1){1'b0}}};

  logic [2*SIGN_W-1:0] mem [MAX_COLUMNS];
  logic [2*SIGN_W-1:0] rd_word;

  logic                     stg_valid;
  logic                     stg_first_row;
  logic                     stg_first_col;
  logic [COL_W-1:0]         stg_col;
  logic signed [SIGN_W-1:0] stg_key;
  logic signed [SIGN_W-1:0] run_first;
  logic signed [SIGN_W-1:0] run_second;

  logic signed [SIGN_W-1:0] up_first, up_second, rn_first, rn_second;
  logic signed [SIGN_W-1:0] max_first, max_second, new_first, new_second, diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else begin
      stg_valid <= sweep_ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_ctl.issue) begin
      rd_word       <= mem[sweep_col];
      stg_col       <= sweep_col;
      stg_first_row <= sweep_ctl.first_row;
      stg_first_col <= sweep_ctl.first_col;
      stg_key       <= $signed(SIGN_W'(sweep_row)) - $signed(SIGN_W'(sweep_col));
    end
    if (stg_valid) begin
      mem[stg_col] <= {new_first, new_second};
      run_first    <= new_first;
      run_second   <= new_second;
    end
  end

  always_comb begin
    up_first   = stg_first_row ? NONE_MARK : $signed(rd_word[2*SIGN_W-1 -: SIGN_W]);
    up_second  = stg_first_row ? NONE_MARK : $signed(rd_word[SIGN_W-1:0]);
    rn_first   = stg_first_col ? NONE_MARK : run_first;
    rn_second  = stg_first_col ? NONE_MARK : run_second;
    max_first  = (up_first > rn_first) ? up_first : rn_first;
    max_second = (up_second > rn_second) ? up_second : rn_second;
    new_first  = max_first;
    new_second = max_second;
    cand_valid = 1'b0;
    diff       = '0;
    case (sweep_class)
      gntcd_pkg::CLASS_FIRST: begin
        cand_valid = stg_valid && (max_second != NONE_MARK);
        diff       = stg_key - max_second;
        new_first  = stg_key;
      end
      gntcd_pkg::CLASS_SECOND: begin
        cand_valid = stg_valid && (max_first != NONE_MARK);
        diff       = stg_key - max_first;
        new_second = stg_key;
      end
      default: begin
      end
    endcase
    cand_dist = KEY_W'(diff);
  end

endmodule

`default_nettype wire

// File: hw/rtl/gntcd_checker.sv
// ----------------------------------------------------------------------------
// Grid nearest two-class distance: port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "grid_nearest_two_class_distance_defines.svh"

module gntcd_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         cell_valid,
  input wire logic                         cell_ready,
  input wire logic                         result_valid,
  input wire logic                         result_ready,
  input wire logic [gntcd_pkg::DIST_W-1:0] distance_plus_one,
  input wire logic                         pair_found
);

  `GNTCD_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(distance_plus_one) && $stable(pair_found), "result item changed while stalled")
  `GNTCD_ASSERT_NOW(a_no_pair_zero, clk, rst, result_valid && !pair_found, distance_plus_one == '0, "result without a pair carries a distance")
  `GNTCD_ASSERT_NOW(a_sweep_gap, clk, rst, $rose(result_valid), !$past(cell_valid && cell_ready), "result appeared straight after a cell item")
  `GNTCD_ASSERT_RESET(a_reset_quiet, clk, rst, !result_valid, "result valid straight after reset")

endmodule

bind grid_nearest_two_class_distance gntcd_checker u_checker (.*);

`default_nettype wire
